// ----- hw/rtl/rlms_pkg.sv -----
package rlms_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int COORD_BITS  = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0]          count_t;

    typedef struct packed {
        coord_t line;
        coord_t left;
        coord_t right;
    } run_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] line;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] right;
    } piece_t;

    // Control from the sequencer to the queue.
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    // Status from the queue to the sequencer.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

// ----- hw/rtl/rlms_if.sv -----
interface rlms_in_if;
    import rlms_pkg::*;
    logic   valid;
    logic   ready;
    logic   op;
    coord_t line;
    coord_t left;
    coord_t right;
    modport source (output valid, op, line, left, right, input ready);
    modport sink (input valid, op, line, left, right, output ready);
endinterface

interface rlms_out_if;
    import rlms_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_line;
    logic [COORD_BITS-1:0] out_left;
    logic [COORD_BITS-1:0] out_right;
    logic                  last;
    logic                  overflow;
    modport source (output valid, out_line, out_left, out_right, last, overflow,
                    input ready);
    modport sink (input valid, out_line, out_left, out_right, last, overflow,
                  output ready);
endinterface

interface rlms_cfg_if;
    import rlms_pkg::*;
    logic   valid;
    logic   ready;
    coord_t data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/rlms_cell.sv -----
module rlms_cell
    import rlms_pkg::*;
(
    input  logic        clk,
    input  queue_ctrl_t ctrl,
    input  logic        sel,
    input  run_t        push_data,
    input  run_t        neighbor,
    output run_t        data
);

    run_t data_reg;

    // On a pop every cell takes the run of its neighbor toward the tail.
    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            data_reg <= neighbor;
        end
        else if (ctrl.push && sel)
        begin
            data_reg <= push_data;
        end
    end

    assign data = data_reg;

endmodule

// ----- hw/rtl/rlms_queue.sv -----
module rlms_queue
    import rlms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_ctrl_t ctrl,
    input  run_t        push_data,
    output run_t        head,
    output queue_stat_t stat
);

    count_t count_reg;
    count_t count_next;
    run_t   chain [QUEUE_DEPTH+1];

    assign chain[QUEUE_DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            rlms_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .sel       (count_reg == CNT_BITS'(gi)),
                .push_data (push_data),
                .neighbor  (chain[gi+1]),
                .data      (chain[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.pop && count_reg != '0)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
        else if (ctrl.push && count_reg != CNT_BITS'(QUEUE_DEPTH))
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head       = chain[0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));

endmodule

// ----- hw/rtl/run_length_mask_subtract_unit.sv -----
// Run-length mask subtraction.
// in_run carries runs (op, line, left, right). A word with op 0 is a
// subtrahend run and goes into a 32-run queue; when the queue is full it
// is dropped and the sticky overflow bit is set until reset.
// A word with op 1 is a minuend run: after it is accepted, the unit discards
// the queued runs that lie wholly before it, tests the head run, walks past
// each covering run, makes a last test when a covering run reaches beyond
// its right end, and then finishes the run.
// The walk pops the head cell of the queue chain, so the next input word
// is taken only when the run is finished.
// out_piece gives the uncovered pieces with columns minus col_origin; last
// marks the final piece of a run, a fully covered run gives no word.
// One piece is held back to learn whether it is the last, so each piece
// passes through a holding register before the output register.
// cfg writes col_origin; it is always ready and should be written idle.
// A stalled receiver holds the output word and pauses the walk.
// Reset empties the queue, clears overflow and sets col_origin to zero.
module run_length_mask_subtract_unit
    import rlms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rlms_in_if.sink    in_run,
    rlms_out_if.source out_piece,
    rlms_cfg_if.sink   cfg
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DISCARD = 3'd1;
    localparam logic [2:0] ST_WALK    = 3'd2;
    localparam logic [2:0] ST_GAP     = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0]  state_reg, state_next;
    run_t        cur_reg;
    coord_t      origin_reg;
    logic        overflow_reg;
    coord_t      gap_left_reg;
    logic        pend_valid_reg;
    piece_t      pend_reg;
    logic        out_valid_reg;
    piece_t      out_reg;
    logic        out_last_reg;
    logic        out_ovf_reg;

    queue_ctrl_t qctrl;
    queue_stat_t qstat;
    run_t        head;
    run_t        push_run;

    logic        emit;
    coord_t      emit_a, emit_b;
    logic        flush;
    logic        out_free;
    logic        can_move;
    logic        head_same;
    logic        take;

    assign push_run.line  = in_run.line;
    assign push_run.left  = in_run.left;
    assign push_run.right = in_run.right;

    rlms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (qctrl),
        .push_data (push_run),
        .head      (head),
        .stat      (qstat)
    );

    assign out_free  = !out_valid_reg || out_piece.ready;
    assign can_move  = !pend_valid_reg || out_free;
    assign head_same = !qstat.empty && (head.line == cur_reg.line);
    assign in_run.ready = (state_reg == ST_IDLE);
    assign take      = in_run.valid && in_run.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        qctrl      = '0;
        emit       = 1'b0;
        emit_a     = cur_reg.left;
        emit_b     = cur_reg.right;
        flush      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (in_run.op)
                    begin
                        state_next = ST_DISCARD;
                    end
                    else
                    begin
                        qctrl.push = 1'b1;
                    end
                end
            end
            ST_DISCARD:
            begin
                if (!qstat.empty && (head.line < cur_reg.line ||
                    (head.line == cur_reg.line && cur_reg.left > head.right)))
                begin
                    qctrl.pop = 1'b1;
                end
                else if (qstat.empty || head.line > cur_reg.line ||
                         cur_reg.right < head.left)
                begin
                    // No queued run touches this one: it goes out whole.
                    if (can_move)
                    begin
                        emit       = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
                else if (head.left > cur_reg.left)
                begin
                    if (can_move)
                    begin
                        emit       = 1'b1;
                        emit_b     = head.left - COORD_BITS'(1);
                        state_next = ST_WALK;
                    end
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (head.right < cur_reg.right)
                begin
                    qctrl.pop  = 1'b1;
                    state_next = ST_GAP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_GAP:
            begin
                // The gap ends at the next covering run on this line, if any.
                if (can_move)
                begin
                    emit   = 1'b1;
                    emit_a = gap_left_reg;
                    if (head_same && cur_reg.right >= head.left)
                    begin
                        emit_b = head.left - COORD_BITS'(1);
                    end
                    if (head_same && cur_reg.right > head.right)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            origin_reg     <= '0;
            overflow_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                origin_reg <= cfg.data;
            end
            if (take && !in_run.op && qstat.full)
            begin
                overflow_reg <= 1'b1;
            end
            if (emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((emit && pend_valid_reg) || flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_piece.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= push_run;
        end
        if (state_reg == ST_WALK)
        begin
            gap_left_reg <= head.right + COORD_BITS'(1);
        end
        if (emit)
        begin
            pend_reg.line  <= cur_reg.line;
            pend_reg.left  <= emit_a - origin_reg;
            pend_reg.right <= emit_b - origin_reg;
        end
        if ((emit && pend_valid_reg) || flush)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= flush;
            out_ovf_reg  <= overflow_reg;
        end
    end

    assign out_piece.valid     = out_valid_reg;
    assign out_piece.out_line  = out_reg.line;
    assign out_piece.out_left  = out_reg.left;
    assign out_piece.out_right = out_reg.right;
    assign out_piece.last      = out_last_reg;
    assign out_piece.overflow  = out_ovf_reg;

endmodule
